// ===== sv/ftr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fat tree edge switch router package
// Shared widths, message codes, result types and helper functions.
// ----------------------------------------------------------------------------
package ftr_pkg;

  localparam int PORTS    = 8;
  localparam int HALF     = PORTS / 2;
  localparam int PORT_W   = 3;
  localparam int HALF_W   = $clog2(HALF);
  localparam int ID_W     = 8;
  localparam int NODE_W   = 10;
  localparam int DATA_W   = 32;
  localparam int LEVEL_W  = 8;
  localparam int LEVELS_W = 32;
  localparam int KIND_W   = 3;
  localparam int OP_W     = 2;
  localparam int ERR_W    = 4;
  localparam int MAX_RES  = 4;
  localparam int CNT_W    = $clog2(MAX_RES + 1);

  typedef enum logic [KIND_W-1:0] {
    MSG_UNICAST   = 3'd0,
    MSG_BROADCAST = 3'd1,
    MSG_BARRIER   = 3'd2,
    MSG_RELEASE   = 3'd3,
    MSG_REDUCE    = 3'd4,
    MSG_ERROR     = 3'd5
  } msg_kind_t;

  typedef enum logic [OP_W-1:0] {
    OP_MAX = 2'd0,
    OP_MIN = 2'd1,
    OP_SUM = 2'd2,
    OP_MUL = 2'd3
  } red_op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE         = 4'd0,
    ERR_BARRIER_UP   = 4'd1,
    ERR_RELEASE_DOWN = 4'd2,
    ERR_UPRED_UP     = 4'd3,
    ERR_OTHER_BUSY   = 4'd4,
    ERR_DUPLICATE    = 4'd5,
    ERR_DEST         = 4'd6,
    ERR_OP           = 4'd7,
    ERR_SELF         = 4'd8
  } err_code_t;

  typedef struct packed {
    logic [KIND_W-1:0]   req_type;
    logic [PORT_W-1:0]   src_port;
    logic [NODE_W-1:0]   dest_node;
    logic [OP_W-1:0]     op_kind;
    logic [DATA_W-1:0]   payload;
    logic [LEVELS_W-1:0] up_levels;
  } item_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [KIND_W-1:0] kind;
    logic [NODE_W-1:0] dest;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] data;
    logic [ERR_W-1:0]  err;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]         cnt;
    res_t [MAX_RES-1:0]       res;
  } bundle_t;

  function automatic res_t mk_res(input logic [PORT_W-1:0] port,
                                  input logic [KIND_W-1:0] kind,
                                  input logic [NODE_W-1:0] dest,
                                  input logic [OP_W-1:0]   op,
                                  input logic [DATA_W-1:0] data,
                                  input logic [ERR_W-1:0]  err);
    res_t r;
    r.port = port;
    r.kind = kind;
    r.dest = dest;
    r.op   = op;
    r.data = data;
    r.err  = err;
    return r;
  endfunction

  // Queue level of one up port; ports whose field lies past the word read as 0.
  function automatic logic [LEVEL_W-1:0] level_of(input logic [LEVELS_W-1:0] levels,
                                                  input int idx);
    if (idx * LEVEL_W >= LEVELS_W) begin
      return '0;
    end
    return LEVEL_W'(levels >> (idx * LEVEL_W));
  endfunction

  // Least-loaded up port, lowest index on ties.
  function automatic logic [PORT_W-1:0] least_up(input logic [LEVELS_W-1:0] levels);
    logic [LEVEL_W-1:0] best_lvl;
    logic [LEVEL_W-1:0] lvl;
    logic [PORT_W-1:0]  best;
    best     = '0;
    best_lvl = level_of(levels, 0);
    for (int i = 1; i < HALF; i++) begin
      lvl = level_of(levels, i);
      if (lvl < best_lvl) begin
        best_lvl = lvl;
        best     = PORT_W'(i);
      end
    end
    return best;
  endfunction

  function automatic logic [DATA_W-1:0] combine(input logic [OP_W-1:0]   op,
                                                input logic [DATA_W-1:0] acc,
                                                input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    case (op)
      OP_MAX:  r = ($signed(acc) < $signed(v)) ? v : acc;
      OP_MIN:  r = ($signed(v) < $signed(acc)) ? v : acc;
      OP_SUM:  r = DATA_W'(acc + v);
      OP_MUL:  r = DATA_W'(acc * v);
      default: r = acc;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/ftr_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fat tree router decision engine
// Routes one registered item, keeps barrier and reduction state, and builds
// the bundle of results that the item causes.
// ----------------------------------------------------------------------------
module ftr_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  ftr_pkg::item_t            item,
  input  logic [ftr_pkg::ID_W-1:0]  switch_id,
  output ftr_pkg::bundle_t          bundle
);
  import ftr_pkg::*;

  logic [HALF-1:0]   release_seen_r, release_seen_nxt;
  logic              up_busy_r, up_busy_nxt;
  logic [NODE_W-1:0] up_target_r, up_target_nxt;
  logic [OP_W-1:0]   up_op_r, up_op_nxt;
  logic [DATA_W-1:0] up_accum_r, up_accum_nxt;
  logic [HALF-1:0]   up_seen_r, up_seen_nxt;
  logic              down_busy_r, down_busy_nxt;
  logic [NODE_W-1:0] down_target_r, down_target_nxt;
  logic [OP_W-1:0]   down_op_r, down_op_nxt;
  logic [DATA_W-1:0] down_accum_r, down_accum_nxt;
  logic [PORTS-1:0]  down_seen_r, down_seen_nxt;

  logic [NODE_W-1:0] base;
  logic [NODE_W-1:0] diff;
  logic              owned;
  logic [PORT_W-1:0] dport;
  logic [PORT_W-1:0] lu_port;
  logic              from_down;
  logic [HALF-1:0]   up_bit;
  logic [PORTS-1:0]  down_bit;
  logic [HALF-1:0]   rel_new;
  logic [HALF-1:0]   up_seen_new;
  logic [PORTS-1:0]  down_seen_new;
  logic [DATA_W-1:0] comb_val;
  logic [ERR_W-1:0]  err;
  logic [CNT_W-1:0]  n;

  localparam logic [HALF-1:0] DOWN_ALL = '1;

  assign base      = NODE_W'(switch_id) * NODE_W'(HALF);
  assign diff      = item.dest_node - base;
  assign owned     = (item.dest_node >= base) && (diff < NODE_W'(HALF));
  assign dport     = owned ? (PORT_W'(HALF) + PORT_W'(diff[HALF_W-1:0])) : '0;
  assign lu_port   = least_up(item.up_levels);
  assign from_down = item.src_port >= PORT_W'(HALF);
  assign up_bit    = HALF'(1) << item.src_port[HALF_W-1:0];
  assign down_bit  = PORTS'(1) << item.src_port;
  assign rel_new   = release_seen_r | up_bit;
  assign up_seen_new   = up_seen_r | up_bit;
  assign down_seen_new = down_seen_r | down_bit;

  // One shared combine unit: only one direction joins per item.
  assign comb_val = owned ? combine(down_op_r, down_accum_r, item.payload)
                          : combine(up_op_r, up_accum_r, item.payload);

  always_comb begin
    release_seen_nxt = release_seen_r;
    up_busy_nxt      = up_busy_r;
    up_target_nxt    = up_target_r;
    up_op_nxt        = up_op_r;
    up_accum_nxt     = up_accum_r;
    up_seen_nxt      = up_seen_r;
    down_busy_nxt    = down_busy_r;
    down_target_nxt  = down_target_r;
    down_op_nxt      = down_op_r;
    down_accum_nxt   = down_accum_r;
    down_seen_nxt    = down_seen_r;
    bundle           = '0;
    err              = ERR_NONE;
    n                = '0;

    case (item.req_type)
      MSG_UNICAST: begin
        bundle.res[0] = mk_res(owned ? dport : lu_port, MSG_UNICAST, item.dest_node,
                               '0, item.payload, ERR_NONE);
        n = CNT_W'(1);
      end
      MSG_BROADCAST: begin
        for (int i = HALF; i < PORTS; i++) begin
          if (!from_down || item.src_port != PORT_W'(i)) begin
            bundle.res[n[HALF_W-1:0]] = mk_res(PORT_W'(i), MSG_BROADCAST, '0, '0,
                                               item.payload, ERR_NONE);
            n = n + CNT_W'(1);
          end
        end
        if (from_down) begin
          bundle.res[n[HALF_W-1:0]] = mk_res(lu_port, MSG_BROADCAST, '0, '0,
                                             item.payload, ERR_NONE);
          n = n + CNT_W'(1);
        end
      end
      MSG_BARRIER: begin
        if (!from_down) begin
          err = ERR_BARRIER_UP;
        end else begin
          for (int i = 0; i < HALF; i++) begin
            bundle.res[i] = mk_res(PORT_W'(i), MSG_BARRIER, '0, '0, '0, ERR_NONE);
          end
          n = CNT_W'(HALF);
        end
      end
      MSG_RELEASE: begin
        if (from_down) begin
          err = ERR_RELEASE_DOWN;
        end else if (rel_new == DOWN_ALL) begin
          for (int i = 0; i < HALF; i++) begin
            bundle.res[i] = mk_res(PORT_W'(HALF + i), MSG_RELEASE, '0, '0, '0, ERR_NONE);
          end
          n = CNT_W'(HALF);
          release_seen_nxt = '0;
        end else begin
          release_seen_nxt = rel_new;
        end
      end
      MSG_REDUCE: begin
        if (!owned) begin
          if (!from_down) begin
            err = ERR_UPRED_UP;
          end else if (down_busy_r) begin
            err = ERR_OTHER_BUSY;
          end else if (!up_busy_r) begin
            up_busy_nxt   = 1'b1;
            up_target_nxt = item.dest_node;
            up_op_nxt     = item.op_kind;
            up_accum_nxt  = item.payload;
            up_seen_nxt   = up_bit;
          end else if ((up_seen_r & up_bit) != '0) begin
            err = ERR_DUPLICATE;
          end else if (item.dest_node != up_target_r) begin
            err = ERR_DEST;
          end else if (item.op_kind != up_op_r) begin
            err = ERR_OP;
          end else if (up_seen_new == DOWN_ALL) begin
            bundle.res[0] = mk_res(PORT_W'(switch_id[HALF_W-1:0]), MSG_REDUCE,
                                   up_target_r, up_op_r, comb_val, ERR_NONE);
            n            = CNT_W'(1);
            up_busy_nxt  = 1'b0;
            up_seen_nxt  = '0;
            up_accum_nxt = comb_val;
          end else begin
            up_accum_nxt = comb_val;
            up_seen_nxt  = up_seen_new;
          end
        end else begin
          if (up_busy_r) begin
            err = ERR_OTHER_BUSY;
          end else if (!down_busy_r) begin
            if (item.src_port == dport) begin
              err = ERR_SELF;
            end else begin
              down_busy_nxt   = 1'b1;
              down_target_nxt = item.dest_node;
              down_op_nxt     = item.op_kind;
              down_accum_nxt  = item.payload;
              down_seen_nxt   = down_bit;
            end
          end else if ((down_seen_r & down_bit) != '0) begin
            err = ERR_DUPLICATE;
          end else if (item.dest_node != down_target_r) begin
            err = ERR_DEST;
          end else if (item.op_kind != down_op_r) begin
            err = ERR_OP;
          end else if (item.src_port == dport) begin
            err = ERR_SELF;
          end else if ($countones(down_seen_new) == PORTS - 1) begin
            bundle.res[0] = mk_res(dport, MSG_REDUCE, down_target_r, down_op_r,
                                   comb_val, ERR_NONE);
            n              = CNT_W'(1);
            down_busy_nxt  = 1'b0;
            down_seen_nxt  = '0;
            down_accum_nxt = comb_val;
          end else begin
            down_accum_nxt = comb_val;
            down_seen_nxt  = down_seen_new;
          end
        end
      end
      default: begin
        n = '0;
      end
    endcase

    if (err != ERR_NONE) begin
      bundle.res[0] = mk_res(item.src_port, MSG_ERROR, '0, '0, '0, err);
      n = CNT_W'(1);
    end
    bundle.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_seen_r <= '0;
      up_busy_r      <= 1'b0;
      up_seen_r      <= '0;
      down_busy_r    <= 1'b0;
      down_seen_r    <= '0;
    end else if (fire) begin
      release_seen_r <= release_seen_nxt;
      up_busy_r      <= up_busy_nxt;
      up_seen_r      <= up_seen_nxt;
      down_busy_r    <= down_busy_nxt;
      down_seen_r    <= down_seen_nxt;
    end
  end

  // Reduction data is only read while its direction is busy.
  always_ff @(posedge clk) begin
    if (fire) begin
      up_target_r   <= up_target_nxt;
      up_op_r       <= up_op_nxt;
      up_accum_r    <= up_accum_nxt;
      down_target_r <= down_target_nxt;
      down_op_r     <= down_op_nxt;
      down_accum_r  <= down_accum_nxt;
    end
  end

  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    !(up_busy_r && down_busy_r))
    else $error("both reduction directions busy");

  a_up_seen_busy: assert property (@(posedge clk) disable iff (!rst_n)
    up_busy_r == (up_seen_r != '0))
    else $error("up reduction contributor mask disagrees with busy flag");

  a_down_seen_busy: assert property (@(posedge clk) disable iff (!rst_n)
    down_busy_r == (down_seen_r != '0))
    else $error("down reduction contributor mask disagrees with busy flag");

endmodule

// ===== sv/ftr_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fat tree router result emitter
// Holds one bundle of results; drains one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module ftr_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  ftr_pkg::bundle_t            bundle,
  output logic                        load_ok,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ftr_pkg::res_t               out_res,
  output logic                        out_last
);
  import ftr_pkg::*;

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  res_t [MAX_RES-1:0] q_r, q_nxt;
  logic               take;

  assign out_valid = cnt_r != '0;
  assign take      = out_valid && out_ready;
  assign out_res   = q_r[0];
  assign out_last  = cnt_r == CNT_W'(1);
  assign load_ok   = (cnt_r == '0) || (take && out_last);

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt   = q_r;
    if (take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (load) begin
      q_nxt   = bundle.res;
      cnt_nxt = bundle.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RES))
    else $error("result count out of range");

  a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
    (take && cnt_r > CNT_W'(1)) |=> (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("bundle did not drain by one result");

endmodule

// ===== sv/fat_tree_edge_reduce_router_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fat tree edge switch router with in-network reduction
// Top level: input register, switch id register, decision engine and
// result emitter.
// ----------------------------------------------------------------------------
// Path: an item is held in the input register, then in the result register.
// Throughput: one item per cycle while out_ready is high and it makes at most
//   one result; an item with more (at most four) holds the result register.
// Reset: synchronous active-low rst_n clears switch_id, the barrier and
//   reduction bookkeeping and both channel registers; no clearing pass.
// ----------------------------------------------------------------------------
module fat_tree_edge_reduce_router_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration write channel (switch_id).
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ftr_pkg::ID_W-1:0]             cfg_data,
  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ftr_pkg::KIND_W-1:0]           in_req_type,
  input  logic [ftr_pkg::PORT_W-1:0]           in_src_port,
  input  logic [ftr_pkg::NODE_W-1:0]           in_dest_node,
  input  logic [ftr_pkg::OP_W-1:0]             in_op_kind,
  input  logic signed [ftr_pkg::DATA_W-1:0]    in_payload,
  input  logic [ftr_pkg::LEVELS_W-1:0]         in_up_levels,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ftr_pkg::PORT_W-1:0]           out_port,
  output logic [ftr_pkg::KIND_W-1:0]           out_kind,
  output logic [ftr_pkg::NODE_W-1:0]           out_dest,
  output logic [ftr_pkg::OP_W-1:0]             out_op,
  output logic signed [ftr_pkg::DATA_W-1:0]    out_data,
  output logic [ftr_pkg::ERR_W-1:0]            out_error_code,
  output logic                                 out_last
);
  import ftr_pkg::*;

  logic [ID_W-1:0] switch_id_r;
  logic            in_full_r, in_full_nxt;
  item_t           in_q_r;
  logic            in_take;
  logic            proc_fire;
  logic            emit_ok;
  bundle_t         bundle;
  res_t            res;

  // The switch id may change at any time the block is idle, so the
  // configuration port is always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      switch_id_r <= '0;
    end else if (cfg_valid) begin
      switch_id_r <= cfg_data;
    end
  end

  // Input register. The held item is processed as soon as the emitter can
  // take its bundle, which frees the register in the same cycle; a new
  // transfer is therefore accepted while results of the previous item are
  // still draining.
  assign proc_fire = in_full_r && emit_ok;
  assign in_ready  = !in_full_r || proc_fire;
  assign in_take   = in_valid && in_ready;

  always_comb begin
    in_full_nxt = in_full_r;
    if (in_take) begin
      in_full_nxt = 1'b1;
    end else if (proc_fire) begin
      in_full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else begin
      in_full_r <= in_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_r.req_type  <= in_req_type;
      in_q_r.src_port  <= in_src_port;
      in_q_r.dest_node <= in_dest_node;
      in_q_r.op_kind   <= in_op_kind;
      in_q_r.payload   <= in_payload;
      in_q_r.up_levels <= in_up_levels;
    end
  end

  // Routing, barrier collection and reduction: all state changes happen at
  // the edge where the item moves into the result bundle.
  ftr_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (proc_fire),
    .item      (in_q_r),
    .switch_id (switch_id_r),
    .bundle    (bundle)
  );

  // Result register: up to four results leave one transfer per cycle while
  // out_ready is high, the last one flagged.
  ftr_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (proc_fire),
    .bundle    (bundle),
    .load_ok   (emit_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .out_last  (out_last)
  );

  assign out_port       = res.port;
  assign out_kind       = res.kind;
  assign out_dest       = res.dest;
  assign out_op         = res.op;
  assign out_data       = res.data;
  assign out_error_code = res.err;

endmodule
